>>> src/sset_pkg.sv
// shared types, widths and status codes for the sorted set
package sset_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int VALUE_W          = 32;
   localparam int INDEX_W          = 4;
   localparam int STATUS_W         = 3;
   localparam int COUNT_W          = 5;
   localparam int READ_SPAN        = 1 << INDEX_W;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUP       = 3'd1,
      ST_FULL      = 3'd2,
      ST_READ_OK   = 3'd3,
      ST_BAD_INDEX = 3'd4
   } status_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic                      upd;
      logic signed [VALUE_W-1:0] value;
   } bcast_type;

endpackage

>>> src/sset_cell.sv
// one storage cell of the sorted chain: compares and shifts in from its left neighbour
module sset_cell #(
   parameter int IDX = 0,
   parameter int HW  = 5
) (
   input  logic                               clock,
   input  sset_pkg::bcast_type                bcast,
   input  logic [HW-1:0]                      held,
   input  logic                               left_gt,
   input  logic signed [sset_pkg::VALUE_W-1:0] left_entry,
   output logic                               gt,
   output logic                               eq,
   output logic signed [sset_pkg::VALUE_W-1:0] entry
);

   logic signed [sset_pkg::VALUE_W-1:0] entry_ff;
   logic signed [sset_pkg::VALUE_W-1:0] entry_in;
   logic                                occupied;
   logic                                at_end;

   assign occupied = HW'(IDX) < held;
   assign at_end   = held == HW'(IDX);
   assign gt       = occupied & (entry_ff > bcast.value);
   assign eq       = occupied & (entry_ff == bcast.value);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (bcast.upd) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt || at_end) begin
            // first slot above the new value, or the first free slot
            entry_in = bcast.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> src/sorted_set_insert.sv
// top level: sorted set of signed values held in a chain of compare-and-shift cells
// the response is registered and valid in the cycle after the request is accepted
// throughput: one request per cycle; all cells compare and shift in parallel
// a pending response holds off new requests only while the response side stalls
// reset: synchronous, clears the entry count and the response valid; entries are not cleared
module sorted_set_insert #(
   parameter int CAPACITY = sset_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [0:0]                          req_kind,
   input  logic signed [sset_pkg::VALUE_W-1:0] req_value,
   input  logic [sset_pkg::INDEX_W-1:0]        req_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sset_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [sset_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [sset_pkg::COUNT_W-1:0]        rsp_count
);

   localparam int HW = $clog2(CAPACITY + 1);
   localparam int NR = (CAPACITY < sset_pkg::READ_SPAN) ? CAPACITY : sset_pkg::READ_SPAN;
   localparam int CW = ((HW > sset_pkg::INDEX_W) ? HW : sset_pkg::INDEX_W) + 1;

   logic [HW-1:0]                        held_ff, held_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   sset_pkg::status_type                 status_ff, status_in;
   logic signed [sset_pkg::VALUE_W-1:0]  rd_ff, rd_in;
   logic [HW-1:0]                        count_ff;

   logic                                 accept;
   logic                                 dup;
   logic                                 full;
   logic                                 idx_ok;
   logic signed [sset_pkg::VALUE_W-1:0]  rd_sel;
   sset_pkg::bcast_type                  bcast;
   logic [CAPACITY-1:0]                  gt_v, eq_v;
   logic signed [sset_pkg::VALUE_W-1:0]  entry_v [CAPACITY];
   logic [HW+sset_pkg::COUNT_W-1:0]      count_wide;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign dup       = |eq_v;
   assign full      = held_ff >= HW'(CAPACITY);
   assign idx_ok    = CW'(req_index) < CW'(held_ff);

   assign bcast.upd   = accept & (req_kind == sset_pkg::KIND_INSERT) & ~dup & ~full;
   assign bcast.value = req_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         sset_cell #(.IDX(i), .HW(HW)) u_cell (
            .clock      (clock),
            .bcast      (bcast),
            .held       (held_ff),
            .left_gt    (1'b0),
            .left_entry (req_value),
            .gt         (gt_v[i]),
            .eq         (eq_v[i]),
            .entry      (entry_v[i])
         );
      end else begin : g_rest
         sset_cell #(.IDX(i), .HW(HW)) u_cell (
            .clock      (clock),
            .bcast      (bcast),
            .held       (held_ff),
            .left_gt    (gt_v[i-1]),
            .left_entry (entry_v[i-1]),
            .gt         (gt_v[i]),
            .eq         (eq_v[i]),
            .entry      (entry_v[i])
         );
      end
   end

   // only the first positions are reachable by the index field
   always_comb begin
      rd_sel = '0;
      for (int j = 0; j < NR; j++) begin
         if (CW'(req_index) == CW'(j)) begin
            rd_sel = entry_v[j];
         end
      end
   end

   always_comb begin
      held_in   = held_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      if (accept) begin
         rd_in = '0;
         if (req_kind == sset_pkg::KIND_INSERT) begin
            if (dup) begin
               status_in = sset_pkg::ST_DUP;
            end else if (full) begin
               status_in = sset_pkg::ST_FULL;
            end else begin
               status_in = sset_pkg::ST_INSERTED;
               held_in   = held_ff + 1'b1;
            end
         end else if (idx_ok) begin
            status_in = sset_pkg::ST_READ_OK;
            rd_in     = rd_sel;
         end else begin
            status_in = sset_pkg::ST_BAD_INDEX;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rd_ff     <= rd_in;
      if (accept) begin
         count_ff <= held_in;
      end
   end

   assign count_wide     = {{sset_pkg::COUNT_W{1'b0}}, count_ff};
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_value = rd_ff;
   assign rsp_count      = count_wide[sset_pkg::COUNT_W-1:0];

endmodule

>>> src/sset_checker.sv
// port-level checks on the sorted set, bound to the top level
module sset_checker #(
   parameter int CAPACITY = sset_pkg::CAPACITY_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [sset_pkg::STATUS_W-1:0]       rsp_status,
   input logic signed [sset_pkg::VALUE_W-1:0] rsp_read_value,
   input logic [sset_pkg::COUNT_W-1:0]        rsp_count
);

   // requests are held off only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a pending response");

   // an accepted request always produces a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request gave no response");

   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != sset_pkg::ST_READ_OK) |-> (rsp_read_value == 0))
      else $error("read value not zero outside a valid read");

   // an insert leaves at least one entry, a full reject means the set is at capacity
   a_count_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == sset_pkg::ST_INSERTED || rsp_status == sset_pkg::ST_FULL))
      |-> (rsp_count != 0))
      else $error("count empty after insert or full reject");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind sorted_set_insert sset_checker #(.CAPACITY(CAPACITY)) u_sset_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_read_value (rsp_read_value),
   .rsp_count      (rsp_count)
);
